@@ rtl/aus_pkg.sv @@
package aus_pkg;

    // Number of orientation axes handled side by side.
    localparam int AXES = 3;

    // Field widths fixed by the interface.
    localparam int RAW_W   = 16;
    localparam int OUT_W   = 32;
    localparam int ALPHA_W = 16;

    // Raw deltas are formed with headroom so that the wrap never overflows.
    localparam int DELTA_W = 18;

    // Half and full turn in 1/64 degree units.
    localparam logic signed [DELTA_W-1:0] HALF_TURN = 18'sd11520;
    localparam logic signed [DELTA_W-1:0] FULL_TURN = 18'sd23040;

    // Reset value of the smoothing weight, Q0.16.
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd53216;

endpackage

@@ rtl/angle_unwrap_smoother.sv @@
// Three-axis angle unwrap and smoothing block.
// Input channel (i_in_valid / o_in_ready) carries one frame per beat: an
// optional raw reading of three angles in 1/64 degree units and a re-zero
// request. Output channel (o_out_valid / i_out_ready) returns one beat per
// frame with the three smoothed, unwrapped angles and the anchored flag.
// The smoothing weight is written through i_cfg_wr_en / i_cfg_wr_data and
// should only change while no frame is in flight.
// The datapath is three register stages: the input register, the unwrap
// stage that updates the continuous angles, and the smoothing stage whose
// state registers also drive the result. A frame moves from the input
// register to the unwrap stage and then to the smoothing stage. One frame
// can be accepted every cycle, since each stage takes a new beat in the
// same cycle that it hands its own on. When the receiver stalls, the
// result holds and each stage keeps taking beats until it fills, so up to
// three frames are held before o_in_ready drops. Reset clears all angles,
// the anchor, the pipeline and restores the default smoothing weight.
module angle_unwrap_smoother #(
    parameter int ACC_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [aus_pkg::ALPHA_W-1:0]         i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_has_reading,
    input  logic                                i_rezero,
    input  logic signed [aus_pkg::RAW_W-1:0]    i_raw_first,
    input  logic signed [aus_pkg::RAW_W-1:0]    i_raw_second,
    input  logic signed [aus_pkg::RAW_W-1:0]    i_raw_third,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [aus_pkg::OUT_W-1:0]    o_smooth_first,
    output logic signed [aus_pkg::OUT_W-1:0]    o_smooth_second,
    output logic signed [aus_pkg::OUT_W-1:0]    o_smooth_third,
    output logic                                o_anchored
);

    localparam int AXES = aus_pkg::AXES;

    // Configuration.
    logic [aus_pkg::ALPHA_W-1:0] r_alpha;

    // Input register stage.
    logic                                r_in_valid;
    logic                                r_in_has;
    logic                                r_in_rezero;
    logic signed [aus_pkg::RAW_W-1:0]    r_in_raw [AXES];

    // Unwrap stage: the continuous angle state doubles as its output.
    logic                                r_a_valid;
    logic                                r_a_rezero;
    logic                                r_anchor;
    logic signed [aus_pkg::RAW_W-1:0]    r_prev [AXES];
    logic signed [ACC_BITS-1:0]          r_cont [AXES];
    logic signed [ACC_BITS-1:0]          n_cont [AXES];
    logic signed [ACC_BITS-1:0]          cont_base [AXES];
    logic signed [ACC_BITS-1:0]          cont_step [AXES];

    // Smoothing stage: the smoothed state is also the result register.
    logic                                r_out_valid;
    logic                                r_out_anchor;
    logic signed [ACC_BITS-1:0]          r_smooth [AXES];
    logic signed [ACC_BITS-1:0]          n_smooth [AXES];
    logic signed [ACC_BITS-1:0]          smooth_base [AXES];
    logic signed [aus_pkg::OUT_W-1:0]    smooth_out [AXES];

    // Stage advance: a stage moves when it holds a beat and the one after
    // it is empty or moving on in the same cycle.
    logic move_out;
    logic move_a;
    logic move_in;

    assign move_out = r_a_valid && (!r_out_valid || i_out_ready);
    assign move_a   = r_in_valid && (!r_a_valid || move_out);
    assign move_in  = i_in_valid && o_in_ready;

    assign o_in_ready  = !r_in_valid || move_a;
    assign o_out_valid = r_out_valid;
    assign o_anchored  = r_out_anchor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= aus_pkg::ALPHA_RESET;
        end else if (i_cfg_wr_en) begin
            r_alpha <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move_in) begin
            r_in_has    <= i_has_reading;
            r_in_rezero <= i_rezero;
            r_in_raw[0] <= i_raw_first;
            r_in_raw[1] <= i_raw_second;
            r_in_raw[2] <= i_raw_third;
        end
    end

    // Unwrap stage. Re-zero clears the continuous angle first; the first
    // reading after reset only anchors the previous raw values.
    for (genvar g = 0; g < AXES; g++) begin : g_unwrap
        assign cont_base[g] = r_in_rezero ? '0 : r_cont[g];

        aus_unwrap #(
            .ACC_BITS (ACC_BITS)
        ) u_unwrap (
            .i_raw  (r_in_raw[g]),
            .i_prev (r_prev[g]),
            .i_cont (cont_base[g]),
            .o_cont (cont_step[g])
        );

        always_comb begin
            if (r_in_has) begin
                n_cont[g] = r_anchor ? cont_step[g] : '0;
            end else begin
                n_cont[g] = cont_base[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_a_rezero <= 1'b0;
            r_anchor   <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_prev[i] <= '0;
                r_cont[i] <= '0;
            end
        end else begin
            if (move_a) begin
                r_a_valid  <= 1'b1;
                r_a_rezero <= r_in_rezero;
                for (int i = 0; i < AXES; i++) begin
                    r_cont[i] <= n_cont[i];
                end
                if (r_in_has) begin
                    r_anchor <= 1'b1;
                    for (int i = 0; i < AXES; i++) begin
                        r_prev[i] <= r_in_raw[i];
                    end
                end
            end else if (move_out) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Smoothing stage.
    for (genvar g = 0; g < AXES; g++) begin : g_smooth
        assign smooth_base[g] = r_a_rezero ? '0 : r_smooth[g];

        aus_ema #(
            .ACC_BITS (ACC_BITS)
        ) u_ema (
            .i_alpha  (r_alpha),
            .i_cont   (r_cont[g]),
            .i_smooth (smooth_base[g]),
            .o_smooth (n_smooth[g])
        );

        // Clamp to the 32-bit result range when the accumulator is wider.
        if (ACC_BITS > aus_pkg::OUT_W) begin : g_clamp
            always_comb begin
                if (r_smooth[g] > ACC_BITS'(32'sh7FFF_FFFF)) begin
                    smooth_out[g] = 32'sh7FFF_FFFF;
                end else if (r_smooth[g] < ACC_BITS'(32'sh8000_0000)) begin
                    smooth_out[g] = 32'sh8000_0000;
                end else begin
                    smooth_out[g] = $signed(r_smooth[g][aus_pkg::OUT_W-1:0]);
                end
            end
        end else begin : g_extend
            assign smooth_out[g] = aus_pkg::OUT_W'(r_smooth[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out_anchor <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_smooth[i] <= '0;
            end
        end else begin
            if (move_out) begin
                r_out_valid  <= 1'b1;
                r_out_anchor <= r_anchor;
                for (int i = 0; i < AXES; i++) begin
                    r_smooth[i] <= n_smooth[i];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_smooth_first  = smooth_out[0];
    assign o_smooth_second = smooth_out[1];
    assign o_smooth_third  = smooth_out[2];

`ifndef NO_ASSERTIONS
    // Once anchored, the block stays anchored until reset.
    a_anchor_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_anchor |=> r_anchor)
        else $error("anchor flag dropped");

    // The new smoothed value of the first axis always lies between the continuous
    // angle and the previous smoothed value, or zero after a re-zero.
    a_smooth_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move_out |-> ((n_smooth[0] >= r_cont[0] && n_smooth[0] <= smooth_base[0]) ||
                      (n_smooth[0] <= r_cont[0] && n_smooth[0] >= smooth_base[0])))
        else $error("smoothed angle outside its bounds");

    // The input side only stalls when every stage holds a beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_a_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ rtl/aus_unwrap.sv @@
module aus_unwrap #(
    parameter int ACC_BITS = 32
) (
    input  logic signed [aus_pkg::RAW_W-1:0] i_raw,
    input  logic signed [aus_pkg::RAW_W-1:0] i_prev,
    input  logic signed [ACC_BITS-1:0]       i_cont,
    output logic signed [ACC_BITS-1:0]       o_cont
);

    logic signed [aus_pkg::DELTA_W-1:0] delta_raw;
    logic signed [aus_pkg::DELTA_W-1:0] delta_hi;
    logic signed [aus_pkg::DELTA_W-1:0] delta;
    logic signed [ACC_BITS:0]           sum;

    // The change is wrapped once: first from above, then, tested on that
    // result, from below.
    assign delta_raw = aus_pkg::DELTA_W'(i_raw) - aus_pkg::DELTA_W'(i_prev);
    assign delta_hi  = (delta_raw > aus_pkg::HALF_TURN) ?
                       delta_raw - aus_pkg::FULL_TURN : delta_raw;
    assign delta     = (delta_hi < -aus_pkg::HALF_TURN) ?
                       delta_hi + aus_pkg::FULL_TURN : delta_hi;

    assign sum = (ACC_BITS+1)'(i_cont) + (ACC_BITS+1)'(delta);

    // Saturate to the accumulator range when the two top bits disagree.
    always_comb begin
        if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
            o_cont = sum[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}}
                                   : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            o_cont = $signed(sum[ACC_BITS-1:0]);
        end
    end

endmodule

@@ rtl/aus_ema.sv @@
module aus_ema #(
    parameter int ACC_BITS = 32
) (
    input  logic [aus_pkg::ALPHA_W-1:0] i_alpha,
    input  logic signed [ACC_BITS-1:0]  i_cont,
    input  logic signed [ACC_BITS-1:0]  i_smooth,
    output logic signed [ACC_BITS-1:0]  o_smooth
);

    // alpha*s + (1-alpha)*c equals c + alpha*(s - c), so one multiplier
    // suffices and the floor of the sum is c plus the floor of the product.
    logic signed [ACC_BITS:0]                   diff;
    logic signed [aus_pkg::ALPHA_W:0]           alpha_s;
    logic signed [ACC_BITS+aus_pkg::ALPHA_W+1:0] prod;
    logic signed [ACC_BITS+1:0]                 step;
    logic signed [ACC_BITS+1:0]                 total;

    assign diff    = (ACC_BITS+1)'(i_smooth) - (ACC_BITS+1)'(i_cont);
    assign alpha_s = $signed({1'b0, i_alpha});
    assign prod    = diff * alpha_s;
    assign step    = $signed(prod[ACC_BITS+aus_pkg::ALPHA_W+1:aus_pkg::ALPHA_W]);
    assign total   = (ACC_BITS+2)'(i_cont) + step;

    // The result always lies between the two inputs, so it cannot overflow.
    assign o_smooth = $signed(total[ACC_BITS-1:0]);

endmodule
